FILE: rtl/i2csr_pkg.sv
// i2csr_pkg: shared types and constants of the I2C register-map target.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps

package i2csr_pkg;

    // Bus event codes carried in the input tuser; codes 5 to 7 are unused.
    typedef enum logic [2:0] {
        FUNC_START     = 3'd0,
        FUNC_STOP      = 3'd1,
        FUNC_WRITE     = 3'd2,
        FUNC_READ_ACK  = 3'd3,
        FUNC_READ_NACK = 3'd4
    } t_func;

    // Reply kinds carried in the output tuser.
    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_OWN_ADDRESS    = 1'b0;
    localparam logic CFG_IDENTITY_VALUE = 1'b1;

    localparam logic [6:0] OWN_ADDRESS_RST    = 7'h34;
    localparam logic [7:0] IDENTITY_VALUE_RST = 8'h68;
    localparam logic [7:0] IDENT_INDEX        = 8'h75;
    localparam logic [7:0] ACK_DATA           = 8'h01;

    // Store access issued by the controller.
    typedef struct packed {
        logic       rd_en;
        logic       wr_en;
        logic [7:0] ptr;
        logic [7:0] wdata;
    } t_mem_req;

    // Per-event result descriptor handed to the read stage.
    typedef struct packed {
        logic valid;   // event produces a reply
        logic kind;    // KIND_ACK or KIND_READ
        logic ident;   // read hits the identity register
        logic oob;     // read beyond the store, returns zero
    } t_res;

endpackage

FILE: rtl/i2csr_store.sv
// i2csr_store: register-map memory, one write and one read port, registered read.
// Per-entry valid bits make the map read as zero after reset. Uses i2csr_pkg.
`timescale 1ns / 1ps

module i2csr_store #(
    parameter int REG_COUNT = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  i2csr_pkg::t_mem_req i_req,
    output logic [7:0]          o_rdata
);

    localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    logic [7:0]           mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_valid;
    logic [7:0]           r_rdata;
    logic                 r_hit;
    logic [AW-1:0]        idx;

    assign idx = i_req.ptr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[idx] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rdata <= mem[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_hit   <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[idx] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_hit <= r_valid[idx];
            end
        end
    end

    // never-written entry reads as zero
    assign o_rdata = r_hit ? r_rdata : 8'h00;

endmodule

FILE: rtl/i2csr_ctrl.sv
// i2csr_ctrl: bus mode machine, register pointer and store access decode.
// Updates on every accepted event. Uses i2csr_pkg.
`timescale 1ns / 1ps

module i2csr_ctrl #(
    parameter int REG_COUNT = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [2:0]          i_func,
    input  logic [6:0]          i_dev_address,
    input  logic                i_read_not_write,
    input  logic [7:0]          i_data_byte,
    input  logic [6:0]          i_own_address,
    output i2csr_pkg::t_mem_req o_mem_req,
    output i2csr_pkg::t_res     o_res
);

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_WRITE = 3'b010,
        MODE_READ  = 3'b100
    } t_mode;

    t_mode      r_mode, n_mode;
    logic [7:0] r_ptr, n_ptr;
    logic       r_loaded, n_loaded;
    logic       in_range;
    logic       match;
    i2csr_pkg::t_func func;

    assign func     = i2csr_pkg::t_func'(i_func);
    assign match    = (i_dev_address == i_own_address);
    assign in_range = ({1'b0, r_ptr} < 9'(REG_COUNT));

    always_comb begin
        n_mode    = r_mode;
        n_ptr     = r_ptr;
        n_loaded  = r_loaded;
        o_mem_req = '{rd_en: 1'b0, wr_en: 1'b0, ptr: r_ptr, wdata: i_data_byte};
        o_res     = '{valid: 1'b0, kind: i2csr_pkg::KIND_ACK, ident: 1'b0, oob: 1'b0};
        if (i_accept) begin
            if (!match || func == i2csr_pkg::FUNC_STOP) begin
                n_mode = MODE_IDLE;
            end else if (func == i2csr_pkg::FUNC_START) begin
                // start or repeated start: restart, keep the pointer
                n_mode      = i_read_not_write ? MODE_READ : MODE_WRITE;
                n_loaded    = 1'b0;
                o_res.valid = 1'b1;
            end else begin
                unique case (r_mode)
                    MODE_WRITE: begin
                        if (func == i2csr_pkg::FUNC_WRITE) begin
                            o_res.valid = 1'b1;
                            if (!r_loaded) begin
                                n_ptr    = i_data_byte;
                                n_loaded = 1'b1;
                            end else begin
                                o_mem_req.wr_en = in_range;
                                n_ptr           = r_ptr + 8'd1;
                            end
                        end
                    end
                    MODE_READ: begin
                        if (func == i2csr_pkg::FUNC_READ_NACK) begin
                            n_mode = MODE_IDLE;
                        end else if (func == i2csr_pkg::FUNC_READ_ACK) begin
                            o_res.valid     = 1'b1;
                            o_res.kind      = i2csr_pkg::KIND_READ;
                            o_res.ident     = (r_ptr == i2csr_pkg::IDENT_INDEX);
                            o_res.oob       = !in_range;
                            o_mem_req.rd_en = in_range;
                            n_ptr           = r_ptr + 8'd1;
                        end
                    end
                    default: begin
                        // idle: only a start does anything
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_ptr    <= 8'h00;
            r_loaded <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_ptr    <= n_ptr;
            r_loaded <= n_loaded;
        end
    end

endmodule

FILE: rtl/i2c_slave_register_map_core.sv
// i2c_slave_register_map_core: top level of the byte-level I2C register-map target.
// Instantiates i2csr_ctrl and i2csr_store; uses i2csr_pkg.
`timescale 1ns / 1ps

// Byte-level I2C target with a REG_COUNT-byte register map (up to 256). Each transfer on
// the slave stream is one bus event: tuser holds the event code (start, stop, write
// byte, read ack, read nack) and tdata the address, direction and byte. A start to
// own_address is acknowledged and opens a write or read transfer; the first written
// byte loads the register pointer, later bytes are stored with 8-bit wrapping
// post-increment, and each read ack returns the pointed byte (identity_value at 0x75)
// and advances the pointer. A stop, a read nack in a read transfer or a foreign
// address ends the transfer silently. Throughput is one event per clock unless the
// reply stream back-pressures: the pointer and mode live in flops and each event makes
// at most one access to the store. Replies pass the store read stage, then the output
// register. The map reads as zero after reset with no clearing pass. Configuration
// writes belong in gaps with no event in flight; the block does not hold them off.
module i2c_slave_register_map_core #(
    parameter int REG_COUNT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata,
    // event stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [6:0] dev_address, [7] read_not_write, [15:8] data_byte
    input  logic [2:0]  i_s_tuser,   // [2:0] func
    // reply stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [6:0] reply_address, [7] reply_direction,
                                     // [15:8] reply_data
    output logic        o_m_tuser    // [0] reply_kind
);

    logic [6:0] r_own_address;
    logic [7:0] r_identity_value;

    i2csr_pkg::t_mem_req mem_req;
    i2csr_pkg::t_res     res;
    logic [7:0]          rdata;
    logic                s_accept;
    logic                s1_go;

    // read stage: waits for the registered store data
    logic                r_s1_valid;
    i2csr_pkg::t_res     r_s1;
    logic [6:0]          r_s1_addr;
    logic                r_s1_dir;
    logic [7:0]          s1_data;

    // output register
    logic                r_o_valid;
    logic                r_o_kind;
    logic [15:0]         r_o_tdata;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address    <= i2csr_pkg::OWN_ADDRESS_RST;
            r_identity_value <= i2csr_pkg::IDENTITY_VALUE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                i2csr_pkg::CFG_OWN_ADDRESS:    r_own_address    <= i_cfg_wdata[6:0];
                i2csr_pkg::CFG_IDENTITY_VALUE: r_identity_value <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Read stage moves on whenever the output register is free or being drained;
    // a new event may enter while a reply still waits at the output.
    assign s1_go      = !r_o_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || s1_go;
    assign s_accept   = i_s_tvalid && o_s_tready;

    i2csr_ctrl #(
        .REG_COUNT(REG_COUNT)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (s_accept),
        .i_func          (i_s_tuser),
        .i_dev_address   (i_s_tdata[6:0]),
        .i_read_not_write(i_s_tdata[7]),
        .i_data_byte     (i_s_tdata[15:8]),
        .i_own_address   (r_own_address),
        .o_mem_req       (mem_req),
        .o_res           (res)
    );

    // store read data holds until the next read, which only comes with an accept
    i2csr_store #(
        .REG_COUNT(REG_COUNT)
    ) u_store (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mem_req),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_accept) begin
            r_s1_valid <= res.valid;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1      <= res;
            r_s1_addr <= i_s_tdata[6:0];
            r_s1_dir  <= i_s_tdata[7];
        end
    end

    // reply byte: ack constant, identity register, out-of-range zero, or store data
    always_comb begin
        if (r_s1.kind == i2csr_pkg::KIND_ACK) begin
            s1_data = i2csr_pkg::ACK_DATA;
        end else if (r_s1.ident) begin
            s1_data = r_identity_value;
        end else if (r_s1.oob) begin
            s1_data = 8'h00;
        end else begin
            s1_data = rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_go) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_valid) begin
            r_o_kind  <= r_s1.kind;
            r_o_tdata <= {s1_data, r_s1_dir, r_s1_addr};
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_tdata;
    assign o_m_tuser  = r_o_kind;

    // one store access per event
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_req.rd_en && mem_req.wr_en))
        else $error("store read and write issued together");

    // a store read always lands in the read stage as a read reply
    a_read_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.rd_en |=> (r_s1_valid && r_s1.kind == i2csr_pkg::KIND_READ))
        else $error("store read without read reply");

    // read stage drains into an empty output register
    a_s1_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_o_valid) |=> r_o_valid)
        else $error("read stage did not drain");

endmodule
